[rtl/rbd_pkg.sv]
// Shared types, constants and channel arithmetic for the 2x2 box downsampler.
`timescale 1ns / 1ps

package rbd_pkg;

	localparam int OUT_SIDE  = 32;
	localparam int OUT_W     = $clog2(OUT_SIDE);
	localparam int IDX_W     = 2 * OUT_W;
	localparam int CNT_W     = IDX_W + 2;
	localparam int FRAME_OUT = OUT_SIDE * OUT_SIDE;
	localparam int SRC_SIDE  = 2 * OUT_SIDE;
	localparam int DIM_W     = 12;
	localparam int CH_W      = 8;
	localparam int SUM_W     = CH_W + 1;
	localparam int NUM_CH    = 4;
	localparam int PIX_W     = NUM_CH * CH_W;
	localparam int ENTRY_W   = NUM_CH * SUM_W;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;

	typedef struct packed {
		logic [CH_W-1:0] in_alpha;
		logic [CH_W-1:0] in_red;
		logic [CH_W-1:0] in_green;
		logic [CH_W-1:0] in_blue;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_pixel;
		logic [IDX_W-1:0] out_index;
		logic             ok;
		logic             last;
	} out_item_t;

	typedef struct packed {
		logic shift;
		logic rotate;
	} line_ctl_t;

	// Per-channel sum of two horizontally adjacent pixels, nine bits a channel.
	function automatic logic [ENTRY_W-1:0] pair_sum(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b);
		logic [ENTRY_W-1:0] s;
		s = '0;
		for (int k = 0; k < NUM_CH; k++) begin
			s[k*SUM_W +: SUM_W] = SUM_W'(a[k*CH_W +: CH_W]) + SUM_W'(b[k*CH_W +: CH_W]);
		end
		return s;
	endfunction

	// Adds the lower pair to the stored upper pair and divides by four.
	function automatic logic [PIX_W-1:0] box_avg(input logic [ENTRY_W-1:0] upper,
			input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
		logic [PIX_W-1:0]  r;
		logic [SUM_W:0]    t;
		r = '0;
		for (int k = 0; k < NUM_CH; k++) begin
			t = (SUM_W+1)'(upper[k*SUM_W +: SUM_W]) + (SUM_W+1)'(a[k*CH_W +: CH_W])
				+ (SUM_W+1)'(b[k*CH_W +: CH_W]);
			r[k*CH_W +: CH_W] = t[SUM_W:2];
		end
		return r;
	endfunction

endpackage

[rtl/rbd_cell.sv]
// One cell of the line store: holds the pair sums of one output column.
`timescale 1ns / 1ps

module rbd_cell (
	input  logic                        clk,
	input  logic                        shift,
	input  logic [rbd_pkg::ENTRY_W-1:0] d,
	output logic [rbd_pkg::ENTRY_W-1:0] q
);
	import rbd_pkg::*;

	logic [ENTRY_W-1:0] entry_q;

	// Contents are meaningless until an even row has passed through.
	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

[rtl/rbd_line.sv]
// Line store built as a row of cells that shift one place per completed pair.
`timescale 1ns / 1ps

module rbd_line (
	input  logic                        clk,
	input  rbd_pkg::line_ctl_t          ctl,
	input  logic [rbd_pkg::ENTRY_W-1:0] din,
	output logic [rbd_pkg::ENTRY_W-1:0] head
);
	import rbd_pkg::*;

	logic [ENTRY_W-1:0] link [OUT_SIDE+1];

	// On odd rows the oldest entry is read and fed back in, so the row rotates intact.
	assign link[0] = ctl.rotate ? link[OUT_SIDE] : din;
	assign head    = link[OUT_SIDE];

	for (genvar i = 0; i < OUT_SIDE; i++) begin : g_cell
		rbd_cell u_cell (
			.clk   (clk),
			.shift (ctl.shift),
			.d     (link[i]),
			.q     (link[i+1])
		);
	end

endmodule

[rtl/rgba_box_downsample_2x2.sv]
// Top level of the 2x2 box downsampler producing a 32x32 packed ARGB image.
`timescale 1ns / 1ps

// Usage
// Source pixels arrive one item at a time in raster order on in_valid/in_ready
// with in_data; result items leave on out_valid/out_ready with out_data.
// The cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets source_width
// (index 0) and source_height (index 1); cfg_ready is always high, and every
// write to either restarts the image. Write only while the block is idle.
// At 32x32 each item yields its pixel unchanged; at 64x64 the even rows fill
// the line store with horizontal pair sums and every second item of an odd
// row yields the average of one 2x2 block. Any other size yields zero pixels
// with ok cleared for the first 1024 items and nothing after that.
// A result is registered in the output register, or in the skid register on a
// stall. One item is taken every cycle while in_ready is high; the 32-cell line
// store chain shifts once per completed pixel pair, so it never limits the rate.
// A two-entry output buffer (output register plus skid register) keeps input
// accepted while one result waits; in_ready falls only when both are full.
// Reset returns the sizes to 32x32 and clears the pixel count, the held pixel
// and the output buffer; the line store needs no clearing.
module rgba_box_downsample_2x2 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  rbd_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output rbd_pkg::out_item_t            out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rbd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rbd_pkg::DIM_W-1:0]     cfg_data
);
	import rbd_pkg::*;

	logic [DIM_W-1:0]   source_width_q;
	logic [DIM_W-1:0]   source_height_q;
	logic [CNT_W-1:0]   count_q;
	logic [PIX_W-1:0]   held_q;
	logic               out_valid_q;
	logic               skid_valid_q;
	out_item_t          out_q;
	out_item_t          skid_q;

	logic               accept;
	logic               cfg_write;
	logic               copy_mode;
	logic               down_mode;
	logic [PIX_W-1:0]   px;
	logic [OUT_W:0]     col;
	logic [OUT_W:0]     row;
	logic [OUT_W-1:0]   slot;
	logic [ENTRY_W-1:0] line_head;
	line_ctl_t          line_ctl;
	logic               res_valid;
	out_item_t          res;
	logic [CNT_W-1:0]   count_next;
	logic               hold_px;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid & cfg_ready;
	assign in_ready  = ~skid_valid_q;
	assign accept    = in_valid & in_ready;

	assign copy_mode = (source_width_q == DIM_W'(OUT_SIDE))
		&& (source_height_q == DIM_W'(OUT_SIDE));
	assign down_mode = (source_width_q == DIM_W'(SRC_SIDE))
		&& (source_height_q == DIM_W'(SRC_SIDE));

	assign px   = in_data;
	assign col  = count_q[OUT_W:0];
	assign row  = count_q[CNT_W-1:OUT_W+1];
	assign slot = col[OUT_W:1];

	// Decide what the current item produces and how the count moves on.
	always_comb begin
		res_valid       = 1'b0;
		res.out_pixel   = '0;
		res.out_index   = count_q[IDX_W-1:0];
		res.ok          = 1'b0;
		count_next      = count_q;
		hold_px         = 1'b0;
		line_ctl.shift  = 1'b0;
		line_ctl.rotate = 1'b0;
		if (copy_mode) begin
			res_valid     = 1'b1;
			res.out_pixel = px;
			res.ok        = 1'b1;
			count_next    = CNT_W'(count_q[IDX_W-1:0] + IDX_W'(1));
		end else if (down_mode) begin
			// The count wraps exactly at the end of the source image.
			count_next = count_q + CNT_W'(1);
			if (!col[0]) begin
				hold_px = 1'b1;
			end else begin
				line_ctl.shift = 1'b1;
				if (row[0]) begin
					line_ctl.rotate = 1'b1;
					res_valid       = 1'b1;
					res.out_pixel   = box_avg(line_head, held_q, px);
					res.out_index   = {row[OUT_W:1], slot};
					res.ok          = 1'b1;
				end
			end
		end else if (count_q < CNT_W'(FRAME_OUT)) begin
			res_valid  = 1'b1;
			count_next = count_q + CNT_W'(1);
		end
		res.last = (res.out_index == IDX_W'(FRAME_OUT - 1));
	end

	rbd_line u_line (
		.clk  (clk),
		.ctl  ('{shift: line_ctl.shift & accept & ~cfg_write, rotate: line_ctl.rotate}),
		.din  (pair_sum(held_q, px)),
		.head (line_head)
	);

	// Configuration registers, pixel count and held pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_width_q  <= DIM_W'(OUT_SIDE);
			source_height_q <= DIM_W'(OUT_SIDE);
			count_q         <= '0;
			held_q          <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SOURCE_WIDTH:  source_width_q  <= cfg_data;
				REG_SOURCE_HEIGHT: source_height_q <= cfg_data;
				default: ;
			endcase
			if (cfg_index == REG_SOURCE_WIDTH || cfg_index == REG_SOURCE_HEIGHT) begin
				count_q <= '0;
				held_q  <= '0;
			end
		end else if (accept) begin
			count_q <= count_next;
			if (hold_px) begin
				held_q <= px;
			end
		end
	end

	// Output register and skid register: valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && !out_ready) begin
			if (accept && res_valid) begin
				skid_valid_q <= 1'b1;
			end
		end else if (skid_valid_q) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q <= accept & res_valid;
		end
	end

	// Output register and skid register: payload.
	always_ff @(posedge clk) begin
		if (out_valid_q && !out_ready) begin
			if (accept && res_valid) begin
				skid_q <= res;
			end
		end else if (skid_valid_q) begin
			out_q <= skid_q;
		end else if (accept && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[rtl/rbd_checker.sv]
// Port-level checks for the 2x2 box downsampler, bound to its top level.
`timescale 1ns / 1ps

module rbd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input rbd_pkg::out_item_t out_data
);
	import rbd_pkg::*;

	// A stalled result stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result item changed while stalled");

	// Input is refused only when the output buffer holds results.
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input refused with an empty output buffer");

	// The end-of-image flag marks exactly the final output position.
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last == (out_data.out_index == IDX_W'(FRAME_OUT - 1))))
		else $error("last flag does not match the final index");

	// Results for an unsupported size carry a zero pixel.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.ok |-> out_data.out_pixel == '0)
		else $error("unsupported-size result carries a non-zero pixel");

endmodule

bind rgba_box_downsample_2x2 rbd_checker u_rbd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

[dv/testbench.sv]
// Self-checking testbench for the 2x2 box downsampler with its own pixel predictor.
`timescale 1ns / 1ps

module testbench;
	import rbd_pkg::*;

	// Register indexes that the block does not implement. A write to one of them
	// must neither change the sizes nor restart the image.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	// This limit lies far above the length of the slowest correct run, so only a
	// hung handshake can reach it.
	localparam int CYCLE_LIMIT = 250000;
	// Cycles allowed after the last expected item before the block counts as idle.
	localparam int SETTLE_CYCLES = 4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0] cfg_data = '0;

	rgba_box_downsample_2x2 dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Source pixels waiting for the driver, and output pixels the predictor has
	// worked out but the block has not yet delivered, oldest first.
	in_item_t pending_pixels[$];
	out_item_t awaited_pixels[$];

	// Percentage of cycles in which each side holds back.
	int unsigned sender_idle_pct = 0;
	int unsigned receiver_idle_pct = 0;

	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;

	// Predictor state: the two size registers, the position within the current
	// image, the even-column pixel of the current pair and the row of pair sums.
	logic [DIM_W-1:0] src_width = DIM_W'(OUT_SIDE);
	logic [DIM_W-1:0] src_height = DIM_W'(OUT_SIDE);
	int unsigned pixel_pos = 0;
	logic [PIX_W-1:0] held_px = '0;
	logic [ENTRY_W-1:0] pair_sums [OUT_SIDE];

	// Hand-picked pixels for the start of the run: all-zero, all-one, each
	// channel alone at full scale, alternating bits and a few uneven patterns.
	logic [PIX_W-1:0] directed_pixels [12] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_00FF, 32'h0000_FF00,
		32'h00FF_0000, 32'hFF00_0000, 32'hAAAA_AAAA, 32'h5555_5555,
		32'h0102_0408, 32'h8040_2010, 32'hFFFF_FFFE, 32'h7F80_807F
	};

	// Works out what one accepted source pixel produces. In copy mode every pixel
	// comes straight back. In downsample mode an even column is only held; an odd
	// column on an even row stores the pair sums, and an odd column on an odd row
	// adds its pair to the stored sums and yields the block average. Any other size
	// yields zero pixels with ok cleared until one image's worth has gone out.
	function automatic void downsample_pixel(input in_item_t item);
		logic [PIX_W-1:0] px;
		logic [ENTRY_W-1:0] sums;
		logic [SUM_W:0] total;
		out_item_t res;
		int unsigned row;
		int unsigned col;
		int unsigned slot;
		px = item;
		res = '0;
		if (src_width == DIM_W'(OUT_SIDE) && src_height == DIM_W'(OUT_SIDE)) begin
			res.out_pixel = px;
			res.out_index = IDX_W'(pixel_pos);
			res.ok = 1'b1;
			res.last = (pixel_pos == FRAME_OUT - 1);
			awaited_pixels.push_back(res);
			pixel_pos = (pixel_pos + 1) % FRAME_OUT;
		end else if (src_width == DIM_W'(SRC_SIDE) && src_height == DIM_W'(SRC_SIDE)) begin
			row = pixel_pos / SRC_SIDE;
			col = pixel_pos % SRC_SIDE;
			slot = col / 2;
			pixel_pos = (pixel_pos + 1) % (SRC_SIDE * SRC_SIDE);
			if (col % 2 == 0) begin
				held_px = px;
			end else if (row % 2 == 0) begin
				for (int k = 0; k < NUM_CH; k++) begin
					sums[k*SUM_W +: SUM_W] = {1'b0, held_px[k*CH_W +: CH_W]}
						+ {1'b0, px[k*CH_W +: CH_W]};
				end
				pair_sums[slot] = sums;
			end else begin
				for (int k = 0; k < NUM_CH; k++) begin
					total = {1'b0, pair_sums[slot][k*SUM_W +: SUM_W]}
						+ {2'b00, held_px[k*CH_W +: CH_W]} + {2'b00, px[k*CH_W +: CH_W]};
					res.out_pixel[k*CH_W +: CH_W] = total[SUM_W:2];
				end
				res.out_index = IDX_W'((row / 2) * OUT_SIDE + slot);
				res.ok = 1'b1;
				res.last = (res.out_index == IDX_W'(FRAME_OUT - 1));
				awaited_pixels.push_back(res);
			end
		end else if (pixel_pos < FRAME_OUT) begin
			res.out_index = IDX_W'(pixel_pos);
			res.last = (pixel_pos == FRAME_OUT - 1);
			awaited_pixels.push_back(res);
			pixel_pos++;
		end
	endfunction

	// Channels lean towards zero and full scale so that the sums hit their limits.
	function automatic logic [CH_W-1:0] random_channel();
		case ($urandom_range(0, 7))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			default: begin
				return CH_W'($urandom);
			end
		endcase
	endfunction

	function automatic in_item_t random_pixel();
		in_item_t item;
		item.in_blue = random_channel();
		item.in_green = random_channel();
		item.in_red = random_channel();
		item.in_alpha = random_channel();
		return item;
	endfunction

	task automatic queue_random(input int unsigned count);
		repeat (count) pending_pixels.push_back(random_pixel());
	endtask

	// Downsample images from the top-left corner. The first two rows open with
	// a block of full-scale pixels and a block of zero pixels, so that the
	// average reaches both ends of its range; the rest is random.
	task automatic queue_downsample(input int unsigned count);
		int unsigned c;
		for (int unsigned i = 0; i < count; i++) begin
			c = i % (SRC_SIDE * SRC_SIDE);
			if (c / SRC_SIDE < 2 && c % SRC_SIDE < 4) begin
				pending_pixels.push_back('1);
			end else if (c / SRC_SIDE < 2 && c % SRC_SIDE < 8) begin
				pending_pixels.push_back('0);
			end else begin
				pending_pixels.push_back(random_pixel());
			end
		end
	endtask

	// Waits until every queued pixel has been taken and every awaited output has
	// arrived. The check runs on the falling edge, when both handshake blocks have
	// settled. A pixel that yields nothing may still be inside the block, so the task
	// waits out SETTLE_CYCLES before the block is treated as idle.
	task automatic wait_idle();
		do begin
			@(negedge clk);
		end while (pending_pixels.size() != 0 || in_valid || awaited_pixels.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes one register and mirrors the write in the predictor. Both size
	// registers restart the image; the spare indexes change nothing.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_SOURCE_WIDTH: begin
				src_width = value;
				pixel_pos = 0;
				held_px = '0;
			end
			REG_SOURCE_HEIGHT: begin
				src_height = value;
				pixel_pos = 0;
				held_px = '0;
			end
			default: begin
			end
		endcase
	endtask

	// Driver: an item is held until accepted. Once the slot is free the next
	// pixel is offered, unless the sender chooses to idle this cycle. The
	// predictor runs at the edge where the block takes the item.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				downsample_pixel(in_data);
			end
			if (!in_valid || in_ready) begin
				if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= pending_pixels.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: each output item taken is compared field by field with the oldest
	// awaited pixel. The receiver stalls at random by dropping out_ready.
	always @(posedge clk) begin
		out_item_t exp_px;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (awaited_pixels.size() == 0) begin
					$error("output item %h with no pixel awaited", out_data);
					mismatch_count++;
				end else begin
					exp_px = awaited_pixels.pop_front();
					if (out_data.out_pixel !== exp_px.out_pixel) begin
						$error("out_pixel: expected %h, got %h", exp_px.out_pixel,
							out_data.out_pixel);
						mismatch_count++;
					end
					if (out_data.out_index !== exp_px.out_index) begin
						$error("out_index: expected %0d, got %0d", exp_px.out_index,
							out_data.out_index);
						mismatch_count++;
					end
					if (out_data.ok !== exp_px.ok) begin
						$error("ok: expected %b, got %b", exp_px.ok, out_data.ok);
						mismatch_count++;
					end
					if (out_data.last !== exp_px.last) begin
						$error("last: expected %b, got %b", exp_px.last, out_data.last);
						mismatch_count++;
					end
				end
			end
			out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Copy mode at the reset sizes, sender idling lightly and receiver heavily.
		sender_idle_pct = 18;
		receiver_idle_pct = 47;
		@(negedge clk);
		foreach (directed_pixels[i]) pending_pixels.push_back(in_item_t'(directed_pixels[i]));
		queue_random(140);
		wait_idle();

		// Width 64 with height 32 is a mixed size and so unsupported.
		write_reg(REG_SOURCE_WIDTH, DIM_W'(SRC_SIDE));
		queue_random(40);
		wait_idle();

		// The first rows of a 64x64 downsample: the line store is filled, drained
		// and filled again. The two sides swap their idling here.
		write_reg(REG_SOURCE_HEIGHT, DIM_W'(SRC_SIDE));
		sender_idle_pct = 47;
		receiver_idle_pct = 18;
		queue_downsample(3 * SRC_SIDE + 8);
		wait_idle();

		// Unsupported extremes: zero pixels with ok cleared.
		write_reg(REG_SOURCE_WIDTH, '0);
		write_reg(REG_SOURCE_HEIGHT, '1);
		queue_random(60);
		wait_idle();

		// From here on neither side idles.
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		write_reg(REG_SOURCE_WIDTH, '1);
		write_reg(REG_SOURCE_HEIGHT, '0);
		queue_random(20);
		wait_idle();

		// Back to copy mode. Writes to the spare indexes mid-image must leave the
		// pixel position alone, so the indexes carry on from where they were.
		write_reg(REG_SOURCE_WIDTH, DIM_W'(OUT_SIDE));
		write_reg(REG_SOURCE_HEIGHT, DIM_W'(OUT_SIDE));
		queue_random(50);
		wait_idle();
		write_reg(REG_SPARE_A, DIM_W'($urandom));
		write_reg(REG_SPARE_B, DIM_W'($urandom));
		queue_random(50);
		wait_idle();

		// A partial downsample image, cut short by size writes that restart
		// the image and return the block to copy mode.
		write_reg(REG_SOURCE_WIDTH, DIM_W'(SRC_SIDE));
		write_reg(REG_SOURCE_HEIGHT, DIM_W'(SRC_SIDE));
		queue_downsample(100);
		wait_idle();
		write_reg(REG_SOURCE_WIDTH, DIM_W'(OUT_SIDE));
		write_reg(REG_SOURCE_HEIGHT, DIM_W'(OUT_SIDE));
		queue_random(30);
		wait_idle();

		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

[files.f]
rtl/rbd_pkg.sv
rtl/rbd_cell.sv
rtl/rbd_line.sv
rtl/rgba_box_downsample_2x2.sv
rtl/rbd_checker.sv
dv/testbench.sv
